// File: hw/rtl/rsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

    // Field widths
    localparam int VALUE_W = 31;
    localparam int WORD_W  = 2 * VALUE_W;
    localparam int DIGIT_W = 4;
    localparam int NUM_DIGITS = 10;

    // Divide by ten: multiply by reciprocal, exact for any 32-bit operand
    localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_COUNT,
        ST_PREFIX,
        ST_SCATTER,
        ST_OUTPUT
    } rsd_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/radix_sort_decimal_lsd_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Decimal LSD radix sort. Values are loaded one per transaction (start while
// busy is low) until one marked last, or until MAX_ITEMS are held; busy then
// rises and the set is sorted in place between two ping-pong RAMs, each word
// holding the value and its running quotient by the current place value.
// Each pass runs a count sweep, a prefix sum over the buckets and a scatter
// sweep, the pipeline draining after each sweep; sorting stops at the first
// place where every digit is zero or after MAX_DIGITS passes. Results then
// stream out one per cycle on done with no back-pressure, the final one
// flagged by last_res; busy falls once the pipeline has drained after it.
// Loading takes a value per start; one read port per RAM sets the sweep rate.
module radix_sort_decimal_lsd_top #(
    parameter int MAX_ITEMS  = 64,
    parameter int MAX_DIGITS = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [rsd_pkg::VALUE_W-1:0] value,
    input  wire logic                        last,
    output logic                             done,
    output logic      [rsd_pkg::VALUE_W-1:0] sorted_value,
    output logic                             last_res
);

    import rsd_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = $clog2(MAX_DIGITS + 1);

    rsd_state_t state_reg, state_next;

    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic [PW-1:0]      pass_reg, pass_next;
    logic [DIGIT_W-1:0] pfx_reg, pfx_next;
    logic               sel_reg, sel_next;
    logic               nz_reg, nz_next;
    logic [CW-1:0]      cnt_reg [NUM_DIGITS];
    logic [CW-1:0]      cnt_next [NUM_DIGITS];

    logic               s1_vld_reg, s1_last_reg;
    logic               s2_vld_reg;
    logic [VALUE_W-1:0] s2_val_reg, s2_qdiv_reg;
    logic [DIGIT_W-1:0] s2_qlo_reg;

    logic               issue, issue_last;
    logic [AW-1:0]      raddr;
    logic [WORD_W-1:0]  rd0, rd1, src_rd;
    logic [WORD_W-1:0]  wdata;
    logic [AW-1:0]      waddr;
    logic               we0, we1, load, sct_wr;
    logic [62:0]        prod;
    logic [DIGIT_W-1:0] dig;
    logic [CW-1:0]      pos;
    logic               drained;

    // Memories: sel_reg names the one holding the current order
    rsd_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ITEMS)) u_ram0 (
        .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rd0)
    );

    rsd_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ITEMS)) u_ram1 (
        .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rd1)
    );

    assign src_rd = sel_reg ? rd1 : rd0;
    assign busy   = (state_reg != ST_LOAD);
    assign load   = start && !busy;

    // Read issue: forward sweep, reversed during scatter
    assign issue = (rd_idx_reg != n_reg) && (state_reg == ST_COUNT ||
                   state_reg == ST_SCATTER || state_reg == ST_OUTPUT);
    assign issue_last = (rd_idx_reg == n_reg - CW'(1));
    assign raddr = (state_reg == ST_SCATTER) ? AW'(n_reg - CW'(1) - rd_idx_reg)
                                             : AW'(rd_idx_reg);
    assign drained = (rd_idx_reg == n_reg) && !s1_vld_reg && !s2_vld_reg;

    // Quotient by ten straight off the RAM register
    assign prod = 63'(src_rd[VALUE_W-1:0]) * 63'(RECIP_10);

    // Digit = q mod 10 from low bits of q and q/10
    assign dig = s2_qlo_reg - (DIGIT_W'({s2_qdiv_reg[DIGIT_W-1:0], 3'b000}) +
                               DIGIT_W'({s2_qdiv_reg[DIGIT_W-1:0], 1'b0}));
    assign pos = cnt_reg[dig] - CW'(1);

    // Write port: loads into memory 0, scatter into the other memory
    assign sct_wr = (state_reg == ST_SCATTER) && s2_vld_reg;
    assign we0    = load || (sct_wr && sel_reg);
    assign we1    = sct_wr && !sel_reg;
    assign waddr  = load ? AW'(n_reg) : AW'(pos);
    assign wdata  = load ? {value, value} : {s2_val_reg, s2_qdiv_reg};

    // Results
    assign done         = s1_vld_reg && (state_reg == ST_OUTPUT);
    assign sorted_value = src_rd[WORD_W-1:VALUE_W];
    assign last_res     = s1_last_reg;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        rd_idx_next = issue ? rd_idx_reg + CW'(1) : rd_idx_reg;
        pass_next   = pass_reg;
        pfx_next    = pfx_reg;
        sel_next    = sel_reg;
        nz_next     = nz_reg;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (load)
                begin
                    n_next = n_reg + CW'(1);
                    if (last || (n_reg == CW'(MAX_ITEMS - 1)))
                    begin
                        state_next  = ST_COUNT;
                        rd_idx_next = '0;
                        nz_next     = 1'b0;
                        for (int i = 0; i < NUM_DIGITS; i++)
                        begin
                            cnt_next[i] = '0;
                        end
                    end
                end
            end
            ST_COUNT:
            begin
                if (s2_vld_reg)
                begin
                    cnt_next[dig] = cnt_reg[dig] + CW'(1);
                    if (dig != '0)
                    begin
                        nz_next = 1'b1;
                    end
                end
                if (drained)
                begin
                    rd_idx_next = '0;
                    pfx_next    = DIGIT_W'(1);
                    state_next  = nz_reg ? ST_PREFIX : ST_OUTPUT;
                end
            end
            ST_PREFIX:
            begin
                cnt_next[pfx_reg] = cnt_reg[pfx_reg] + cnt_reg[pfx_reg - DIGIT_W'(1)];
                pfx_next = pfx_reg + DIGIT_W'(1);
                if (pfx_reg == DIGIT_W'(NUM_DIGITS - 1))
                begin
                    state_next = ST_SCATTER;
                end
            end
            ST_SCATTER:
            begin
                if (s2_vld_reg)
                begin
                    cnt_next[dig] = pos;
                end
                if (drained)
                begin
                    rd_idx_next = '0;
                    sel_next    = !sel_reg;
                    pass_next   = pass_reg + PW'(1);
                    nz_next     = 1'b0;
                    for (int i = 0; i < NUM_DIGITS; i++)
                    begin
                        cnt_next[i] = '0;
                    end
                    state_next = (pass_reg == PW'(MAX_DIGITS - 1)) ? ST_OUTPUT
                                                                    : ST_COUNT;
                end
            end
            ST_OUTPUT:
            begin
                if (drained)
                begin
                    state_next  = ST_LOAD;
                    n_next      = '0;
                    rd_idx_next = '0;
                    pass_next   = '0;
                    sel_next    = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            n_reg       <= '0;
            rd_idx_reg  <= '0;
            pass_reg    <= '0;
            pfx_reg     <= '0;
            sel_reg     <= 1'b0;
            nz_reg      <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_vld_reg  <= 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            rd_idx_reg  <= rd_idx_next;
            pass_reg    <= pass_next;
            pfx_reg     <= pfx_next;
            sel_reg     <= sel_next;
            nz_reg      <= nz_next;
            s1_vld_reg  <= issue;
            s1_last_reg <= issue && issue_last;
            s2_vld_reg  <= s1_vld_reg && (state_reg != ST_OUTPUT);
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // Datapath stage after the multiplier
    always_ff @(posedge clk)
    begin
        s2_val_reg  <= src_rd[WORD_W-1:VALUE_W];
        s2_qlo_reg  <= src_rd[DIGIT_W-1:0];
        s2_qdiv_reg <= VALUE_W'(prod[62:RECIP_SHIFT]);
    end

`ifndef SYNTHESIS
    // No result while values are being loaded
    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !done)
        else $error("result while loading");

    // Run closes shortly after its final result
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        done && last_res |=> ##1 !busy)
        else $error("run did not close after final result");

    // Scatter never takes a slot from an empty bucket
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCATTER) && s2_vld_reg |-> cnt_reg[dig] != '0)
        else $error("bucket underflow in scatter");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/rsd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rsd_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
